>>> design/resol_pkg.sv
// Shared constants, types and helpers for the ring entry store with offset lookup.
`timescale 1ns / 1ps

package resol_pkg;

  localparam int SLOTS     = 16;
  localparam int IDX_W     = $clog2(SLOTS);
  localparam int CNT_W     = $clog2(SLOTS + 1);
  localparam int HANDLE_W  = 32;
  localparam int LEN_W     = 16;
  localparam int OFF_W     = 20;
  localparam int ENTRY_W   = HANDLE_W + LEN_W;
  localparam int SUM_RAW_W = LEN_W + IDX_W + 1;
  localparam int SUM_W     = (SUM_RAW_W > OFF_W) ? SUM_RAW_W : OFF_W + 1;

  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_FIND = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRIME,
    ST_WALK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic add;
    logic start;
    logic step;
    logic check;
    logic clr_res;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic hit;
    logic last;
    logic out_free;
  } sts_t;

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] r;
    if (i == IDX_W'(SLOTS - 1)) begin
      r = '0;
    end else begin
      r = i + IDX_W'(1);
    end
    return r;
  endfunction

endpackage

>>> design/resol_if.sv
// Request and result channel interfaces with valid/ready handshake.
`timescale 1ns / 1ps

interface resol_req_if;
  logic                           valid;
  logic                           ready;
  logic                           kind;
  logic [resol_pkg::HANDLE_W-1:0] entry_handle;
  logic [resol_pkg::LEN_W-1:0]    entry_length;
  logic [resol_pkg::OFF_W-1:0]    find_offset;

  modport source (output valid, kind, entry_handle, entry_length, find_offset, input ready);
  modport sink (input valid, kind, entry_handle, entry_length, find_offset, output ready);
endinterface

interface resol_res_if;
  logic                           valid;
  logic                           ready;
  logic                           found;
  logic [resol_pkg::HANDLE_W-1:0] hit_handle;
  logic [resol_pkg::LEN_W-1:0]    hit_length;
  logic [resol_pkg::LEN_W-1:0]    byte_in_entry;

  modport source (output valid, found, hit_handle, hit_length, byte_in_entry, input ready);
  modport sink (input valid, found, hit_handle, hit_length, byte_in_entry, output ready);
endinterface

>>> design/resol_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module resol_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> design/resol_ctrl.sv
// Controller state machine: request intake, ring walk sequencing and result hand-off.
`timescale 1ns / 1ps

module resol_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_kind,
  input  resol_pkg::sts_t    sts,
  output logic               in_ready,
  output resol_pkg::cmd_t    cmd
);

  resol_pkg::state_t state_r;
  resol_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= resol_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      resol_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_kind == resol_pkg::KIND_ADD) begin
            cmd.add     = 1'b1;
            cmd.clr_res = 1'b1;
            state_nxt   = resol_pkg::ST_DONE;
          end else if (sts.empty) begin
            cmd.clr_res = 1'b1;
            state_nxt   = resol_pkg::ST_DONE;
          end else begin
            cmd.start = 1'b1;
            state_nxt = resol_pkg::ST_PRIME;
          end
        end
      end
      resol_pkg::ST_PRIME: begin
        cmd.step  = 1'b1;
        state_nxt = resol_pkg::ST_WALK;
      end
      resol_pkg::ST_WALK: begin
        cmd.step  = 1'b1;
        cmd.check = 1'b1;
        if (sts.hit) begin
          state_nxt = resol_pkg::ST_DONE;
        end else if (sts.last) begin
          cmd.clr_res = 1'b1;
          state_nxt   = resol_pkg::ST_DONE;
        end
      end
      resol_pkg::ST_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = resol_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = resol_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  a_walk_after_prime: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == resol_pkg::ST_WALK) |->
      ($past(state_r) == resol_pkg::ST_PRIME || $past(state_r) == resol_pkg::ST_WALK))
    else $error("walk entered without priming the store read");
`endif

endmodule

>>> design/resol_dp.sv
// Datapath: ring indices, entry store, length accumulator and result registers.
`timescale 1ns / 1ps

module resol_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  resol_pkg::cmd_t                cmd,
  output resol_pkg::sts_t                sts,
  input  logic [resol_pkg::HANDLE_W-1:0] in_entry_handle,
  input  logic [resol_pkg::LEN_W-1:0]    in_entry_length,
  input  logic [resol_pkg::OFF_W-1:0]    in_find_offset,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic                           out_found,
  output logic [resol_pkg::HANDLE_W-1:0] out_hit_handle,
  output logic [resol_pkg::LEN_W-1:0]    out_hit_length,
  output logic [resol_pkg::LEN_W-1:0]    out_byte_in_entry
);

  logic [resol_pkg::IDX_W-1:0]    wr_idx_r, wr_idx_nxt;
  logic [resol_pkg::IDX_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic                           full_r, full_nxt;
  logic [resol_pkg::IDX_W-1:0]    walk_idx_r, walk_idx_nxt;
  logic [resol_pkg::CNT_W-1:0]    remain_r, remain_nxt;
  logic [resol_pkg::SUM_W-1:0]    sum_r, sum_nxt;
  logic [resol_pkg::SUM_W-1:0]    off_r, off_nxt;
  logic                           res_found_r, res_found_nxt;
  logic [resol_pkg::HANDLE_W-1:0] res_handle_r, res_handle_nxt;
  logic [resol_pkg::LEN_W-1:0]    res_len_r, res_len_nxt;
  logic [resol_pkg::LEN_W-1:0]    res_byte_r, res_byte_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic                           out_found_r, out_found_nxt;
  logic [resol_pkg::HANDLE_W-1:0] out_handle_r, out_handle_nxt;
  logic [resol_pkg::LEN_W-1:0]    out_len_r, out_len_nxt;
  logic [resol_pkg::LEN_W-1:0]    out_byte_r, out_byte_nxt;

  logic [resol_pkg::ENTRY_W-1:0]  ram_rdata;
  logic [resol_pkg::LEN_W-1:0]    ent_len;
  logic [resol_pkg::HANDLE_W-1:0] ent_handle;
  logic [resol_pkg::SUM_W-1:0]    ent_end;
  logic [resol_pkg::SUM_W-1:0]    ent_rel;
  logic [resol_pkg::CNT_W-1:0]    used;
  logic [resol_pkg::IDX_W-1:0]    wr_next;
  logic                           hit;

  resol_ram #(
    .WIDTH (resol_pkg::ENTRY_W),
    .DEPTH (resol_pkg::SLOTS)
  ) u_store (
    .clk   (clk),
    .we    (cmd.add),
    .waddr (wr_idx_r),
    .wdata ({in_entry_handle, in_entry_length}),
    .raddr (walk_idx_r),
    .rdata (ram_rdata)
  );

  assign ent_len    = ram_rdata[resol_pkg::LEN_W-1:0];
  assign ent_handle = ram_rdata[resol_pkg::ENTRY_W-1:resol_pkg::LEN_W];
  assign ent_end    = sum_r + resol_pkg::SUM_W'(ent_len);
  assign ent_rel    = off_r - sum_r;
  assign hit        = off_r < ent_end;
  assign wr_next    = resol_pkg::next_slot(wr_idx_r);

  always_comb begin
    if (full_r) begin
      used = resol_pkg::CNT_W'(resol_pkg::SLOTS);
    end else if (wr_idx_r >= rd_idx_r) begin
      used = resol_pkg::CNT_W'(wr_idx_r) - resol_pkg::CNT_W'(rd_idx_r);
    end else begin
      used = resol_pkg::CNT_W'(wr_idx_r) + resol_pkg::CNT_W'(resol_pkg::SLOTS)
           - resol_pkg::CNT_W'(rd_idx_r);
    end
  end

  assign sts.empty    = !full_r && (wr_idx_r == rd_idx_r);
  assign sts.hit      = hit;
  assign sts.last     = (remain_r == resol_pkg::CNT_W'(1));
  assign sts.out_free = !out_valid_r || out_ready;

  always_comb begin
    wr_idx_nxt     = wr_idx_r;
    rd_idx_nxt     = rd_idx_r;
    full_nxt       = full_r;
    walk_idx_nxt   = walk_idx_r;
    remain_nxt     = remain_r;
    sum_nxt        = sum_r;
    off_nxt        = off_r;
    res_found_nxt  = res_found_r;
    res_handle_nxt = res_handle_r;
    res_len_nxt    = res_len_r;
    res_byte_nxt   = res_byte_r;
    out_valid_nxt  = out_valid_r;
    out_found_nxt  = out_found_r;
    out_handle_nxt = out_handle_r;
    out_len_nxt    = out_len_r;
    out_byte_nxt   = out_byte_r;

    // overwrite oldest once full
    if (cmd.add) begin
      wr_idx_nxt = wr_next;
      if (full_r) begin
        rd_idx_nxt = resol_pkg::next_slot(rd_idx_r);
      end else if (wr_next == rd_idx_r) begin
        full_nxt = 1'b1;
      end
    end

    if (cmd.start) begin
      walk_idx_nxt = rd_idx_r;
      remain_nxt   = used;
      sum_nxt      = '0;
      off_nxt      = resol_pkg::SUM_W'(in_find_offset);
    end

    if (cmd.step) begin
      walk_idx_nxt = resol_pkg::next_slot(walk_idx_r);
    end

    if (cmd.check) begin
      if (hit) begin
        res_found_nxt  = 1'b1;
        res_handle_nxt = ent_handle;
        res_len_nxt    = ent_len;
        res_byte_nxt   = ent_rel[resol_pkg::LEN_W-1:0];
      end else begin
        sum_nxt    = ent_end;
        remain_nxt = remain_r - resol_pkg::CNT_W'(1);
      end
    end

    if (cmd.clr_res) begin
      res_found_nxt  = 1'b0;
      res_handle_nxt = '0;
      res_len_nxt    = '0;
      res_byte_nxt   = '0;
    end

    if (cmd.load_out) begin
      out_valid_nxt  = 1'b1;
      out_found_nxt  = res_found_r;
      out_handle_nxt = res_handle_r;
      out_len_nxt    = res_len_r;
      out_byte_nxt   = res_byte_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r    <= '0;
      rd_idx_r    <= '0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wr_idx_r    <= wr_idx_nxt;
      rd_idx_r    <= rd_idx_nxt;
      full_r      <= full_nxt;
      out_valid_r <= out_valid_nxt;
    end
    walk_idx_r   <= walk_idx_nxt;
    remain_r     <= remain_nxt;
    sum_r        <= sum_nxt;
    off_r        <= off_nxt;
    res_found_r  <= res_found_nxt;
    res_handle_r <= res_handle_nxt;
    res_len_r    <= res_len_nxt;
    res_byte_r   <= res_byte_nxt;
    out_found_r  <= out_found_nxt;
    out_handle_r <= out_handle_nxt;
    out_len_r    <= out_len_nxt;
    out_byte_r   <= out_byte_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_hit_handle    = out_handle_r;
  assign out_hit_length    = out_len_r;
  assign out_byte_in_entry = out_byte_r;

`ifndef SYNTH
  a_full_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    full_r |=> full_r)
    else $error("ring full flag dropped before reset");

  a_full_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    full_r |-> (wr_idx_r == rd_idx_r))
    else $error("ring full with write and read indices apart");

  a_no_result_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result loaded over an untaken result");
`endif

endmodule

>>> design/ring_entry_store_offset_lookup.sv
// Top level: ring entry store with character offset lookup.
// An add, or a find on an empty ring, goes from idle straight to the done state; other finds
// pass the prime and walk states until the hit or the last stored entry. From done the result
// is loaded into the output registers once the output is free, and only then is a new request
// taken; the walk reads one entry per cycle through the single read port of the entry store.
// Reset clears the ring indices, full flag, controller and result valid; the store holds.
`timescale 1ns / 1ps

module ring_entry_store_offset_lookup (
  input  logic               clk,
  input  logic               rst_n,
  resol_req_if.sink          in_ch,
  resol_res_if.source        out_ch
);

  resol_pkg::cmd_t cmd;
  resol_pkg::sts_t sts;
  logic            in_ready;

  resol_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_kind  (in_ch.kind),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  resol_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_entry_handle   (in_ch.entry_handle),
    .in_entry_length   (in_ch.entry_length),
    .in_find_offset    (in_ch.find_offset),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_found         (out_ch.found),
    .out_hit_handle    (out_ch.hit_handle),
    .out_hit_length    (out_ch.hit_length),
    .out_byte_in_entry (out_ch.byte_in_entry)
  );

  assign in_ch.ready = in_ready;

endmodule
